/* rtl/lmgf_pkg.sv */
// ----------------------------------------------------------------------------
// lmgf_pkg
// Shared types, codes and glyph tables for the LED matrix glyph frame buffer.
// ----------------------------------------------------------------------------
package lmgf_pkg;

  // frame geometry
  localparam int FRAME_ROWS  = 10;
  localparam int ROW_AW      = 4;
  localparam int ROW_W       = 16;
  localparam int WIDE_COLS   = 13;
  localparam int GLYPH_LINES = 5;
  localparam int GLYPH_COUNT = 38;
  localparam int SLOT_W      = 6;
  localparam int PIX_W       = 7;

  localparam logic [ROW_AW-1:0] ROW_TOP    = 4'd0;
  localparam logic [ROW_AW-1:0] ROW_BOTTOM = 4'd9;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_MERGE = 2'd2,
    FUNC_SCAN  = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [1:0] CFG_RED       = 2'd0;
  localparam logic [1:0] CFG_GREEN     = 2'd1;
  localparam logic [1:0] CFG_BLUE      = 2'd2;
  localparam logic [1:0] CFG_WRITE_OFF = 2'd3;

  // glyph code decoding
  localparam logic [7:0] CODE_RAW_MAX  = 8'd9;
  localparam logic [7:0] CODE_DIGIT0   = 8'd48;
  localparam logic [7:0] CODE_DIGIT9   = 8'd57;
  localparam logic [7:0] CODE_COLON    = 8'd58;
  localparam logic [7:0] CODE_APOS     = 8'd39;
  localparam logic [7:0] CODE_LETTER_A = 8'd65;
  localparam logic [7:0] CODE_LETTER_Z = 8'd90;

  localparam logic [SLOT_W-1:0] SLOT_LETTER_A = 6'd10;
  localparam logic [SLOT_W-1:0] SLOT_COLON    = 6'd36;
  localparam logic [SLOT_W-1:0] SLOT_APOS     = 6'd37;
  localparam logic [SLOT_W-1:0] SLOT_NONE     = 6'd63;

  // glyph bitmaps, top line first, bit 0 is the rightmost column
  localparam logic [4:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_LINES] = '{
    '{5'd2, 5'd5, 5'd5, 5'd5, 5'd2},      '{5'd1, 5'd3, 5'd1, 5'd1, 5'd1},
    '{5'd7, 5'd1, 5'd7, 5'd4, 5'd7},      '{5'd7, 5'd1, 5'd7, 5'd1, 5'd7},
    '{5'd5, 5'd5, 5'd7, 5'd1, 5'd1},      '{5'd7, 5'd4, 5'd7, 5'd1, 5'd7},
    '{5'd2, 5'd4, 5'd7, 5'd5, 5'd7},      '{5'd7, 5'd1, 5'd1, 5'd2, 5'd2},
    '{5'd7, 5'd5, 5'd7, 5'd5, 5'd7},      '{5'd7, 5'd5, 5'd7, 5'd1, 5'd2},
    '{5'd2, 5'd5, 5'd7, 5'd5, 5'd5},      '{5'd6, 5'd5, 5'd6, 5'd5, 5'd6},
    '{5'd3, 5'd4, 5'd4, 5'd4, 5'd3},      '{5'd6, 5'd5, 5'd5, 5'd5, 5'd6},
    '{5'd3, 5'd4, 5'd7, 5'd4, 5'd3},      '{5'd7, 5'd4, 5'd7, 5'd4, 5'd4},
    '{5'd3, 5'd4, 5'd4, 5'd5, 5'd3},      '{5'd5, 5'd5, 5'd7, 5'd5, 5'd5},
    '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1},      '{5'd1, 5'd1, 5'd1, 5'd1, 5'd3},
    '{5'd5, 5'd6, 5'd4, 5'd6, 5'd5},      '{5'd4, 5'd4, 5'd4, 5'd4, 5'd7},
    '{5'd17, 5'd27, 5'd21, 5'd17, 5'd17}, '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17},
    '{5'd2, 5'd5, 5'd5, 5'd5, 5'd2},      '{5'd6, 5'd5, 5'd6, 5'd4, 5'd4},
    '{5'd2, 5'd5, 5'd5, 5'd5, 5'd3},      '{5'd6, 5'd5, 5'd6, 5'd5, 5'd5},
    '{5'd3, 5'd4, 5'd2, 5'd1, 5'd6},      '{5'd7, 5'd2, 5'd2, 5'd2, 5'd2},
    '{5'd5, 5'd5, 5'd5, 5'd5, 5'd7},      '{5'd17, 5'd17, 5'd10, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd21, 5'd21, 5'd10}, '{5'd5, 5'd5, 5'd2, 5'd5, 5'd5},
    '{5'd5, 5'd5, 5'd2, 5'd2, 5'd2},      '{5'd7, 5'd1, 5'd2, 5'd4, 5'd7},
    '{5'd0, 5'd1, 5'd0, 5'd1, 5'd0},      '{5'd1, 5'd0, 5'd0, 5'd0, 5'd0}
  };

  // request from the sequencer to the frame store
  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
  } frame_req_t;

  // character code to glyph table slot
  function automatic logic [SLOT_W-1:0] glyph_slot(input logic [7:0] code);
    logic [SLOT_W-1:0] slot;
    slot = SLOT_NONE;
    if (code <= CODE_RAW_MAX) begin
      slot = code[SLOT_W-1:0];
    end else if (code >= CODE_DIGIT0 && code <= CODE_DIGIT9) begin
      slot = SLOT_W'(code - CODE_DIGIT0);
    end else if (code >= CODE_LETTER_A && code <= CODE_LETTER_Z) begin
      slot = SLOT_W'(code - CODE_LETTER_A) + SLOT_LETTER_A;
    end else if (code == CODE_COLON) begin
      slot = SLOT_COLON;
    end else if (code == CODE_APOS) begin
      slot = SLOT_APOS;
    end
    return slot;
  endfunction

  // strip position of the first led of a row
  function automatic logic [PIX_W-1:0] row_base(input logic [ROW_AW-1:0] row);
    logic [PIX_W-1:0] base;
    case (row)
      4'd0:    base = 7'd0;
      4'd1:    base = 7'd13;
      4'd2:    base = 7'd24;
      4'd3:    base = 7'd35;
      4'd4:    base = 7'd46;
      4'd5:    base = 7'd57;
      4'd6:    base = 7'd68;
      4'd7:    base = 7'd79;
      4'd8:    base = 7'd90;
      4'd9:    base = 7'd101;
      default: base = 7'd0;
    endcase
    return base;
  endfunction

endpackage

/* rtl/lmgf_frame_store.sv */
// ----------------------------------------------------------------------------
// lmgf_frame_store
// Ten-row frame memory, one read and one write port, registered read data.
// Per-row valid bits give all-zero rows after reset or a clear.
// ----------------------------------------------------------------------------
module lmgf_frame_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lmgf_pkg::frame_req_t                req,
  output logic [lmgf_pkg::ROW_W-1:0]          rd_data
);
  import lmgf_pkg::*;

  logic [ROW_W-1:0]      mem [FRAME_ROWS];
  logic [FRAME_ROWS-1:0] vld_r;
  logic [ROW_W-1:0]      rd_data_r;
  logic                  rd_vld_r;

  // row storage and read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // valid bits, cleared by reset and by a clear operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // a row never written reads as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* rtl/led_matrix_glyph_framebuffer.sv */
// ----------------------------------------------------------------------------
// led_matrix_glyph_framebuffer
// Glyph frame buffer with serpentine row scanout for a 114-led matrix.
// ----------------------------------------------------------------------------
// One operation is taken at a time; in_ready is high only while the sequencer
// is idle. A clear and an invalid draw, merge or scan leave it idle; a merge
// reads its row and writes it back, and a glyph draw does a read-modify-write
// of each of its five rows through the frame memory read and write ports,
// reads overlapped with the previous write. A row scan fetches the row and
// then steps through its leds (13 for rows 0 and 9, 11 otherwise), with one
// pixel beat per cycle at most; a stalled out_ready holds the scan. Results
// leave through an output register; a waiting beat holds the scan only at a column that sends one.
// ----------------------------------------------------------------------------
module led_matrix_glyph_framebuffer (
  input  logic                              clk,
  input  logic                              rst_n,
  // operation channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [7:0]                        in_glyph_code,
  input  logic [2:0]                        in_glyph_row,
  input  logic [3:0]                        in_shift_left,
  input  logic [3:0]                        in_row_index,
  input  logic [15:0]                       in_row_bits,
  // pixel write channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmgf_pkg::PIX_W-1:0]        out_pixel_index,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_last,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [7:0]                        cfg_data
);
  import lmgf_pkg::*;

  localparam logic [2:0]           GLYPH_ROW_MAX = 3'd5;
  localparam logic [3:0]           SHIFT_MAX     = 4'd10;
  localparam logic [2:0]           LINE_LAST     = 3'd4;
  localparam logic [3:0]           COL_FIRST_WIDE  = 4'd0;
  localparam logic [3:0]           COL_FIRST_INNER = 4'd1;
  localparam logic [3:0]           COL_LAST_WIDE   = 4'd12;
  localparam logic [3:0]           COL_LAST_INNER  = 4'd11;
  localparam logic [WIDE_COLS-1:0] MASK_WIDE     = 13'h1FFF;
  localparam logic [WIDE_COLS-1:0] MASK_INNER    = 13'h0FFE;
  localparam logic [WIDE_COLS-1:0] EM_LAST_ONE   = 13'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_DRAW,
    S_SCAN_LD,
    S_SCAN
  } state_t;

  // frame row that a glyph line lands in
  function automatic logic [ROW_AW-1:0] draw_dest(input logic [2:0] grow,
                                                  input logic [2:0] line);
    return ROW_AW'(GLYPH_LINES) + {1'b0, line} - {1'b0, grow};
  endfunction

  // glyph line placed in row bits, with the corner shift on the outer rows
  function automatic logic [ROW_W-1:0] draw_bits(input logic [SLOT_W-1:0] slot,
                                                 input logic [2:0] line,
                                                 input logic [2:0] grow,
                                                 input logic [3:0] shift);
    logic [4:0] pat;
    logic [5:0] pat6;
    logic       corner;
    pat    = GLYPH_ROM[slot][line];
    corner = (grow == 3'd0 && line == LINE_LAST) ||
             (grow == GLYPH_ROW_MAX && line == 3'd0);
    pat6   = corner ? {pat, 1'b0} : {1'b0, pat};
    return {10'd0, pat6} << shift;
  endfunction

  // row bits in scan order, one per column, corner columns of inner rows off
  function automatic logic [WIDE_COLS-1:0] scan_lit(input logic [ROW_AW-1:0] row,
                                                    input logic [ROW_W-1:0] data);
    logic [WIDE_COLS-1:0] lit;
    logic                 inner;
    logic [3:0]           bidx;
    inner = (row != ROW_TOP) && (row != ROW_BOTTOM);
    for (int k = 0; k < WIDE_COLS; k++) begin
      if (row[0]) begin
        bidx = 4'(k) - {3'd0, inner};
      end else begin
        bidx = 4'(WIDE_COLS - 1 - k) - {3'd0, inner};
      end
      if (inner && (k == 0 || k == WIDE_COLS - 1)) begin
        lit[k] = 1'b0;
      end else begin
        lit[k] = data[bidx];
      end
    end
    return lit;
  endfunction

  state_t                state_r, state_nxt;
  logic [2:0]            line_r, line_nxt;
  logic [2:0]            grow_r, grow_nxt;
  logic [3:0]            shift_r, shift_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [ROW_AW-1:0]     row_r, row_nxt;
  logic [ROW_W-1:0]      bits_r, bits_nxt;
  logic [WIDE_COLS-1:0]  lit_r, lit_nxt;
  logic [WIDE_COLS-1:0]  em_r, em_nxt;
  logic [3:0]            col_r, col_nxt;
  logic [3:0]            col_end_r, col_end_nxt;
  logic [PIX_W-1:0]      px_r, px_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]      out_px_r, out_px_nxt;
  logic [7:0]            out_red_r, out_red_nxt;
  logic [7:0]            out_green_r, out_green_nxt;
  logic [7:0]            out_blue_r, out_blue_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [7:0]            red_r, green_r, blue_r;
  logic                  write_off_r;

  frame_req_t            req;
  logic [ROW_W-1:0]      rd_data;
  logic [SLOT_W-1:0]     in_slot;
  logic                  in_acc;
  logic                  inner;
  logic                  out_free;
  logic                  emit;

  lmgf_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_slot   = glyph_slot(in_glyph_code);
  assign inner     = (row_r != ROW_TOP) && (row_r != ROW_BOTTOM);
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    grow_nxt      = grow_r;
    shift_nxt     = shift_r;
    slot_nxt      = slot_r;
    row_nxt       = row_r;
    bits_nxt      = bits_r;
    lit_nxt       = lit_r;
    em_nxt        = em_r;
    col_nxt       = col_r;
    col_end_nxt   = col_end_r;
    px_nxt        = px_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_px_nxt    = out_px_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_last_nxt  = out_last_r;
    emit          = 1'b0;
    req           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          grow_nxt  = in_glyph_row;
          shift_nxt = in_shift_left;
          slot_nxt  = in_slot;
          row_nxt   = in_row_index;
          bits_nxt  = in_row_bits;
          line_nxt  = 3'd0;
          case (func_t'(in_func))
            FUNC_CLEAR: begin
              req.clr = 1'b1;
            end
            FUNC_DRAW: begin
              if (in_glyph_row <= GLYPH_ROW_MAX && in_shift_left <= SHIFT_MAX &&
                  in_slot != SLOT_NONE) begin
                req.rd_en   = 1'b1;
                req.rd_addr = draw_dest(in_glyph_row, 3'd0);
                state_nxt   = S_DRAW;
              end
            end
            FUNC_MERGE: begin
              if (in_row_index <= ROW_BOTTOM) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_row_index;
                state_nxt   = S_MERGE;
              end
            end
            FUNC_SCAN: begin
              if (in_row_index <= ROW_BOTTOM) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_row_index;
                state_nxt   = S_SCAN_LD;
              end
            end
            default: ;
          endcase
        end
      end

      // write back the merged row
      S_MERGE: begin
        req.wr_en   = 1'b1;
        req.wr_addr = row_r;
        req.wr_data = rd_data | bits_r;
        state_nxt   = S_IDLE;
      end

      // write one glyph line while the next row is read
      S_DRAW: begin
        req.wr_en   = 1'b1;
        req.wr_addr = draw_dest(grow_r, line_r);
        req.wr_data = rd_data | draw_bits(slot_r, line_r, grow_r, shift_r);
        if (line_r == LINE_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = draw_dest(grow_r, line_r + 3'd1);
          line_nxt    = line_r + 3'd1;
        end
      end

      // turn the fetched row into scan order and mark the beats to send
      S_SCAN_LD: begin
        lit_nxt     = scan_lit(row_r, rd_data);
        em_nxt      = scan_lit(row_r, rd_data) |
                      (write_off_r ? (inner ? MASK_INNER : MASK_WIDE) : '0);
        col_nxt     = inner ? COL_FIRST_INNER : COL_FIRST_WIDE;
        col_end_nxt = inner ? COL_LAST_INNER : COL_LAST_WIDE;
        px_nxt      = row_base(row_r);
        state_nxt   = S_SCAN;
      end

      // one column per cycle, held while a beat cannot be placed
      S_SCAN: begin
        if (!em_r[col_r] || out_free) begin
          if (em_r[col_r]) begin
            emit          = 1'b1;
            out_valid_nxt = 1'b1;
            out_px_nxt    = px_r;
            out_red_nxt   = lit_r[col_r] ? red_r : 8'd0;
            out_green_nxt = lit_r[col_r] ? green_r : 8'd0;
            out_blue_nxt  = lit_r[col_r] ? blue_r : 8'd0;
            out_last_nxt  = ((em_r >> col_r) == EM_LAST_ONE);
          end
          col_nxt = col_r + 4'd1;
          px_nxt  = px_r + 7'd1;
          if (col_r == col_end_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    line_r      <= line_nxt;
    grow_r      <= grow_nxt;
    shift_r     <= shift_nxt;
    slot_r      <= slot_nxt;
    row_r       <= row_nxt;
    bits_r      <= bits_nxt;
    lit_r       <= lit_nxt;
    em_r        <= em_nxt;
    col_r       <= col_nxt;
    col_end_r   <= col_end_nxt;
    px_r        <= px_nxt;
    if (emit) begin
      out_px_r    <= out_px_nxt;
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r       <= 8'd255;
      green_r     <= 8'd255;
      blue_r      <= 8'd255;
      write_off_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RED:       red_r       <= cfg_data;
        CFG_GREEN:     green_r     <= cfg_data;
        CFG_BLUE:      blue_r      <= cfg_data;
        CFG_WRITE_OFF: write_off_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_px_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_last        = out_last_r;

endmodule
